/* hdl/tls_sni_pkg.sv */
package tls_sni_pkg;

	// one accepted input byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} in_t;

	// one result item
	typedef struct packed {
		logic        item_kind;
		logic [7:0]  name_byte;
		logic [2:0]  verdict;
		logic [16:0] bytes_needed;
		logic [7:0]  payload_offset;
		logic [16:0] payload_length;
	} out_t;

	// verdict codes
	typedef enum logic [2:0] {
		V_FOUND      = 3'd0,
		V_NONE       = 3'd1,
		V_INCOMPLETE = 3'd2,
		V_NOT_TLS    = 3'd3,
		V_MALFORMED  = 3'd4
	} verdict_t;

	// frame walk phases
	typedef enum logic [8:0] {
		FP_START   = 9'b000000001,
		FP_ETH     = 9'b000000010,
		FP_VLAN    = 9'b000000100,
		FP_IP      = 9'b000001000,
		FP_IPOPT   = 9'b000010000,
		FP_TCP     = 9'b000100000,
		FP_TCPOPT  = 9'b001000000,
		FP_PAYLOAD = 9'b010000000,
		FP_DONE    = 9'b100000000
	} fp_t;

	// tls parse phases
	typedef enum logic [12:0] {
		TP_REC     = 13'b0000000000001,
		TP_HSTYPE  = 13'b0000000000010,
		TP_HSLEN   = 13'b0000000000100,
		TP_SKIP    = 13'b0000000001000,
		TP_SID     = 13'b0000000010000,
		TP_CSLEN   = 13'b0000000100000,
		TP_COMP    = 13'b0000001000000,
		TP_EXTLEN  = 13'b0000010000000,
		TP_EXTHDR  = 13'b0000100000000,
		TP_LISTLEN = 13'b0001000000000,
		TP_ENTRY   = 13'b0010000000000,
		TP_NAME    = 13'b0100000000000,
		TP_DONE    = 13'b1000000000000
	} tp_t;

	// configuration register indexes
	localparam logic REG_INPUT_MODE = 1'b0;
	localparam logic REG_NAME_BUF   = 1'b1;

	// result item kinds
	localparam logic KIND_NAME    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// protocol constants
	localparam logic [7:0]  REC_HANDSHAKE = 8'h16;
	localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETYPE_VLAN = 16'h8100;
	localparam logic [15:0] ETYPE_QINQ = 16'h88a8;
	localparam logic [7:0]  IP_PROTO_TCP = 8'd6;
	localparam logic [12:0] FRAG_OFFSET_MASK = 13'h1fff;
	localparam int unsigned HELLO_FIXED_LEN = 34;
	localparam logic [16:0] PLEN_MAX = 17'h1ffff;

	localparam int unsigned OUT_DEPTH = 4;

	// hostname character class
	function automatic logic name_char_ok(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
			(c >= 8'h30 && c <= 8'h39) || c == 8'h2e || c == 8'h2d || c == 8'h5f;
	endfunction

endpackage

/* hdl/tls_sni_out_fifo.sv */
module tls_sni_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_cnt,
	input  tls_sni_pkg::out_t   item0,
	input  tls_sni_pkg::out_t   item1,
	output logic                space,
	output logic                out_valid,
	input  logic                out_ready,
	output tls_sni_pkg::out_t   out_data
);

	localparam int unsigned AW = $clog2(tls_sni_pkg::OUT_DEPTH);

	tls_sni_pkg::out_t mem_q [tls_sni_pkg::OUT_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = cnt_q != '0;
	assign out_data  = mem_q[rd_q];
	// room for a name byte and a verdict
	assign space     = cnt_q <= (AW+1)'(tls_sni_pkg::OUT_DEPTH - 2);

	// storage
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_q] <= item0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_q + AW'(1)] <= item1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + AW'(push_cnt);
			rd_q  <= rd_q + AW'(pop);
			cnt_q <= cnt_q + (AW+1)'(push_cnt) - (AW+1)'(pop);
		end
	end

endmodule

/* hdl/tls_sni_parser.sv */
module tls_sni_parser #(
	parameter int unsigned MAX_NAME        = 256,
	parameter int unsigned MAX_INPUT_BYTES = 131072
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [16:0]        cfg_data,
	input  logic               in_we,
	input  tls_sni_pkg::in_t   in_data,
	output logic [1:0]         push_cnt,
	output tls_sni_pkg::out_t  item0,
	output tls_sni_pkg::out_t  item1
);

	localparam int unsigned PW = $clog2(MAX_INPUT_BYTES + 1);
	localparam int unsigned EW = ((PW > 17) ? PW : 17) + 1;
	localparam int unsigned HW = (PW > 8) ? PW : 8;
	localparam logic [PW-1:0] MAX_POS = PW'(MAX_INPUT_BYTES);

	// configuration
	logic        mode_q;
	logic [16:0] nbs_q;

	// parse state
	logic [PW-1:0] pos_q, pos_n;
	tls_sni_pkg::fp_t fp_q, fp_n;
	tls_sni_pkg::tp_t tp_q, tp_n, sn_q, sn_n;
	tls_sni_pkg::verdict_t pend_q, pend_n, fv_q, fv_n;
	logic [23:0] acc_q, acc_n;
	logic [2:0]  cnt_q, cnt_n;
	logic        dot_q, dot_n, sni_q, sni_n, raw_q, raw_n, lim_q, lim_n;
	logic [16:0] rec_end_q, rec_end_n;
	logic [EW-1:0] body_end_q, body_end_n, ext_end_q, ext_end_n;
	logic [EW-1:0] cee_q, cee_n, le_q, le_n, su_q, su_n;
	logic [15:0] nrem_q, nrem_n, ntot_q, ntot_n;
	logic [1:0]  vlan_q, vlan_n;
	logic [16:0] ip_end_q, ip_end_n, tlim_q, tlim_n;
	logic [7:0]  pstart_q, pstart_n, hdr_q, hdr_n, verihl_q, verihl_n, proto_q, proto_n;
	logic [PW-1:0] tcnt_q, tcnt_n;
	logic [15:0] etype_q, etype_n, iptot_q, iptot_n, frag_q, frag_n;
	logic [5:0]  ihl_q, ihl_n, tcph_q, tcph_n;

	// per-byte working signals
	logic [7:0]  b;
	logic        eoi;
	tls_sni_pkg::fp_t eff;
	logic [HW-1:0] i;
	logic [EW-1:0] off, ev, eb;
	logic [15:0] v;
	logic        go, done, emit, ip_fin, tcp_fin, aft;
	tls_sni_pkg::tp_t go_ph, ph;
	logic [EW-1:0] ip_fin_off, tcp_fin_off, aft_off;
	tls_sni_pkg::verdict_t vd;
	logic [16:0] need, plen;
	logic [7:0]  poff;
	logic [16:0] rec_len;
	logic [EW-1:0] tcnt_e;

	assign b   = in_data.data_byte;
	assign eoi = in_data.end_of_input;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			nbs_q  <= 17'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				tls_sni_pkg::REG_INPUT_MODE: mode_q <= cfg_data[0];
				tls_sni_pkg::REG_NAME_BUF:   nbs_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state for one byte
	always_comb begin
		pos_n = pos_q; fp_n = fp_q; tp_n = tp_q; sn_n = sn_q;
		pend_n = pend_q; fv_n = fv_q; acc_n = acc_q; cnt_n = cnt_q;
		dot_n = dot_q; sni_n = sni_q; raw_n = raw_q; lim_n = lim_q;
		rec_end_n = rec_end_q; body_end_n = body_end_q; ext_end_n = ext_end_q;
		cee_n = cee_q; le_n = le_q; su_n = su_q; nrem_n = nrem_q; ntot_n = ntot_q;
		vlan_n = vlan_q; ip_end_n = ip_end_q; tlim_n = tlim_q; pstart_n = pstart_q;
		hdr_n = hdr_q; verihl_n = verihl_q; proto_n = proto_q; tcnt_n = tcnt_q;
		etype_n = etype_q; iptot_n = iptot_q; frag_n = frag_q; ihl_n = ihl_q;
		tcph_n = tcph_q;
		go = 1'b0; go_ph = tls_sni_pkg::TP_REC; ph = tls_sni_pkg::TP_REC;
		done = 1'b0; emit = 1'b0;
		ip_fin = 1'b0; tcp_fin = 1'b0; aft = 1'b0;
		ip_fin_off = '0; tcp_fin_off = '0; aft_off = '0;
		eff = fp_q;
		i = HW'(pos_q) - HW'(hdr_q);
		off = EW'(tcnt_q) + EW'(1);
		v = '0; ev = '0; eb = EW'(b);
		rec_len = '0;
		vd = tls_sni_pkg::V_NOT_TLS; need = '0; plen = '0; poff = '0;
		tcnt_e = '0;

		if (pos_q < MAX_POS) begin
			pos_n = pos_q + PW'(1);
			// first byte picks the mode
			if (fp_q == tls_sni_pkg::FP_START) begin
				raw_n = mode_q;
				eff = mode_q ? tls_sni_pkg::FP_PAYLOAD : tls_sni_pkg::FP_ETH;
				if (mode_q) begin
					pstart_n = '0;
					lim_n = 1'b0;
				end
				fp_n = eff;
			end

			case (eff)
				tls_sni_pkg::FP_ETH: begin
					if (pos_q >= PW'(12)) etype_n = {etype_q[7:0], b};
					if (pos_q == PW'(13)) begin
						aft = 1'b1;
						aft_off = EW'(pos_q) + EW'(1);
					end
				end
				tls_sni_pkg::FP_VLAN: begin
					if (i >= HW'(2)) etype_n = {etype_q[7:0], b};
					if (i == HW'(3)) begin
						vlan_n = vlan_q + 2'd1;
						aft = 1'b1;
						aft_off = EW'(pos_q) + EW'(1);
					end
				end
				tls_sni_pkg::FP_IP: begin
					if (i == HW'(0)) verihl_n = b;
					if (i == HW'(2) || i == HW'(3)) iptot_n = {iptot_q[7:0], b};
					if (i == HW'(6) || i == HW'(7)) frag_n = {frag_q[7:0], b};
					if (i == HW'(9)) proto_n = b;
					if (i == HW'(19)) begin
						ihl_n = {verihl_q[3:0], 2'b00};
						if (verihl_q[7:4] != 4'd4) begin
							fv_n = tls_sni_pkg::V_NOT_TLS;
							fp_n = tls_sni_pkg::FP_DONE;
						end else if (ihl_n < 6'd20) begin
							fv_n = tls_sni_pkg::V_MALFORMED;
							fp_n = tls_sni_pkg::FP_DONE;
						end else if (ihl_n == 6'd20) begin
							ip_fin = 1'b1;
							ip_fin_off = EW'(pos_q) + EW'(1);
						end else begin
							fp_n = tls_sni_pkg::FP_IPOPT;
						end
					end
				end
				tls_sni_pkg::FP_IPOPT: begin
					if (i + HW'(1) == HW'(ihl_q)) begin
						ip_fin = 1'b1;
						ip_fin_off = EW'(pos_q) + EW'(1);
					end
				end
				tls_sni_pkg::FP_TCP: begin
					if (i == HW'(12)) tcph_n = {b[7:4], 2'b00};
					if (i == HW'(19)) begin
						if (tcph_q < 6'd20) begin
							fv_n = tls_sni_pkg::V_MALFORMED;
							fp_n = tls_sni_pkg::FP_DONE;
						end else if (tcph_q == 6'd20) begin
							tcp_fin = 1'b1;
							tcp_fin_off = EW'(pos_q) + EW'(1);
						end else begin
							fp_n = tls_sni_pkg::FP_TCPOPT;
						end
					end
				end
				tls_sni_pkg::FP_TCPOPT: begin
					if (i + HW'(1) == HW'(tcph_q)) begin
						tcp_fin = 1'b1;
						tcp_fin_off = EW'(pos_q) + EW'(1);
					end
				end
				tls_sni_pkg::FP_PAYLOAD: begin
					if (!lim_n || EW'(tcnt_q) < EW'(tlim_q)) begin
						tcnt_n = tcnt_q + PW'(1);
						if (tp_q != tls_sni_pkg::TP_DONE) begin
							acc_n = {acc_q[15:0], b};
							cnt_n = (cnt_q == 3'd7) ? 3'd7 : cnt_q + 3'd1;
							v = acc_n[15:0];
							ev = EW'(v);
							case (tp_q)
								tls_sni_pkg::TP_REC: begin
									if (tcnt_q == '0 && b != tls_sni_pkg::REC_HANDSHAKE) begin
										pend_n = tls_sni_pkg::V_NOT_TLS;
										tp_n = tls_sni_pkg::TP_DONE;
									end else if (cnt_n == 3'd5) begin
										rec_end_n = 17'd5 + {1'b0, v};
										if (v < 16'd4) begin
											pend_n = tls_sni_pkg::V_MALFORMED;
											tp_n = tls_sni_pkg::TP_DONE;
										end else begin
											go = 1'b1; go_ph = tls_sni_pkg::TP_HSTYPE;
										end
									end
								end
								tls_sni_pkg::TP_HSTYPE: begin
									if (b != tls_sni_pkg::HS_CLIENT_HELLO) begin
										pend_n = tls_sni_pkg::V_NOT_TLS;
										tp_n = tls_sni_pkg::TP_DONE;
									end else begin
										go = 1'b1; go_ph = tls_sni_pkg::TP_HSLEN;
									end
								end
								tls_sni_pkg::TP_HSLEN: begin
									if (cnt_n == 3'd3) begin
										rec_len = rec_end_q - 17'd5;
										if (acc_n < 24'(tls_sni_pkg::HELLO_FIXED_LEN) ||
											acc_n > 24'(rec_len - 17'd4)) begin
											pend_n = tls_sni_pkg::V_MALFORMED;
											tp_n = tls_sni_pkg::TP_DONE;
										end else begin
											body_end_n = EW'(acc_n[16:0]) + EW'(9);
											su_n = EW'(9 + tls_sni_pkg::HELLO_FIXED_LEN);
											sn_n = tls_sni_pkg::TP_SID;
											go = 1'b1; go_ph = tls_sni_pkg::TP_SKIP;
										end
									end
								end
								tls_sni_pkg::TP_SKIP: begin
									go = 1'b1; go_ph = tls_sni_pkg::TP_SKIP;
								end
								tls_sni_pkg::TP_SID: begin
									if (off + eb > body_end_q) begin
										pend_n = tls_sni_pkg::V_MALFORMED;
										tp_n = tls_sni_pkg::TP_DONE;
									end else begin
										su_n = off + eb; sn_n = tls_sni_pkg::TP_CSLEN;
										go = 1'b1; go_ph = tls_sni_pkg::TP_SKIP;
									end
								end
								tls_sni_pkg::TP_CSLEN: begin
									if (cnt_n == 3'd2) begin
										if (off + ev > body_end_q || v < 16'd2 || v[0]) begin
											pend_n = tls_sni_pkg::V_MALFORMED;
											tp_n = tls_sni_pkg::TP_DONE;
										end else begin
											su_n = off + ev; sn_n = tls_sni_pkg::TP_COMP;
											go = 1'b1; go_ph = tls_sni_pkg::TP_SKIP;
										end
									end
								end
								tls_sni_pkg::TP_COMP: begin
									if (b == 8'd0 || off + eb > body_end_q) begin
										pend_n = tls_sni_pkg::V_MALFORMED;
										tp_n = tls_sni_pkg::TP_DONE;
									end else begin
										su_n = off + eb; sn_n = tls_sni_pkg::TP_EXTLEN;
										go = 1'b1; go_ph = tls_sni_pkg::TP_SKIP;
									end
								end
								tls_sni_pkg::TP_EXTLEN: begin
									if (cnt_n == 3'd2) begin
										if (off + ev > body_end_q) begin
											pend_n = tls_sni_pkg::V_MALFORMED;
											tp_n = tls_sni_pkg::TP_DONE;
										end else begin
											ext_end_n = off + ev;
											go = 1'b1; go_ph = tls_sni_pkg::TP_EXTHDR;
										end
									end
								end
								tls_sni_pkg::TP_EXTHDR: begin
									if (cnt_n == 3'd2) sni_n = (v == 16'd0);
									if (cnt_n == 3'd4) begin
										if (off + ev > ext_end_q) begin
											pend_n = tls_sni_pkg::V_MALFORMED;
											tp_n = tls_sni_pkg::TP_DONE;
										end else if (!sni_q) begin
											su_n = off + ev; sn_n = tls_sni_pkg::TP_EXTHDR;
											go = 1'b1; go_ph = tls_sni_pkg::TP_SKIP;
										end else begin
											cee_n = off + ev;
											go = 1'b1; go_ph = tls_sni_pkg::TP_LISTLEN;
										end
									end
								end
								tls_sni_pkg::TP_LISTLEN: begin
									if (cnt_n == 3'd2) begin
										if (off + ev > cee_q) begin
											pend_n = tls_sni_pkg::V_MALFORMED;
											tp_n = tls_sni_pkg::TP_DONE;
										end else begin
											le_n = off + ev;
											go = 1'b1; go_ph = tls_sni_pkg::TP_ENTRY;
										end
									end
								end
								tls_sni_pkg::TP_ENTRY: begin
									if (cnt_n == 3'd3) begin
										if (off + ev > le_q) begin
											pend_n = tls_sni_pkg::V_MALFORMED;
											tp_n = tls_sni_pkg::TP_DONE;
										end else if (acc_n[23:16] != 8'd0) begin
											su_n = off + ev; sn_n = tls_sni_pkg::TP_ENTRY;
											go = 1'b1; go_ph = tls_sni_pkg::TP_SKIP;
										end else if (v == 16'd0 || {1'b0, v} >= nbs_q ||
											{1'b0, v} >= 17'(MAX_NAME)) begin
											pend_n = tls_sni_pkg::V_MALFORMED;
											tp_n = tls_sni_pkg::TP_DONE;
										end else begin
											ntot_n = v; nrem_n = v; dot_n = 1'b0;
											tp_n = tls_sni_pkg::TP_NAME;
										end
									end
								end
								tls_sni_pkg::TP_NAME: begin
									if (!tls_sni_pkg::name_char_ok(b)) begin
										pend_n = tls_sni_pkg::V_MALFORMED;
										tp_n = tls_sni_pkg::TP_DONE;
									end else begin
										dot_n = dot_q || (b == 8'h2e);
										nrem_n = nrem_q - 16'd1;
										// trailing root dot is dropped
										emit = !(nrem_n == 16'd0 && b == 8'h2e && ntot_q > 16'd1);
										if (nrem_n == 16'd0) begin
											pend_n = (!dot_n && ntot_q < 16'd4) ?
												tls_sni_pkg::V_MALFORMED : tls_sni_pkg::V_FOUND;
											tp_n = tls_sni_pkg::TP_DONE;
										end
									end
								end
								default: ;
							endcase
						end
					end
				end
				default: ;
			endcase

			// ethertype dispatch
			if (aft) begin
				hdr_n = aft_off[7:0];
				if ((etype_n == tls_sni_pkg::ETYPE_VLAN || etype_n == tls_sni_pkg::ETYPE_QINQ)
					&& vlan_n < 2'd2) begin
					fp_n = tls_sni_pkg::FP_VLAN;
				end else if (etype_n == tls_sni_pkg::ETYPE_IPV4) begin
					fp_n = tls_sni_pkg::FP_IP;
				end else begin
					fv_n = tls_sni_pkg::V_NOT_TLS;
					fp_n = tls_sni_pkg::FP_DONE;
				end
			end

			// end of ip header
			if (ip_fin) begin
				if (iptot_q < 16'(ihl_n)) begin
					fv_n = tls_sni_pkg::V_MALFORMED;
					fp_n = tls_sni_pkg::FP_DONE;
				end else if (proto_q != tls_sni_pkg::IP_PROTO_TCP ||
					(frag_q[12:0] & tls_sni_pkg::FRAG_OFFSET_MASK) != 13'd0) begin
					fv_n = tls_sni_pkg::V_NOT_TLS;
					fp_n = tls_sni_pkg::FP_DONE;
				end else begin
					ip_end_n = 17'(hdr_q) + 17'(iptot_q);
					hdr_n = ip_fin_off[7:0];
					fp_n = tls_sni_pkg::FP_TCP;
				end
			end

			// end of tcp header
			if (tcp_fin) begin
				pstart_n = tcp_fin_off[7:0];
				lim_n = EW'(ip_end_q) > tcp_fin_off;
				tlim_n = lim_n ? ip_end_q - tcp_fin_off[16:0] : 17'd0;
				fp_n = tls_sni_pkg::FP_PAYLOAD;
			end

			// phase entry with its bounds checks
			if (go) begin
				ph = go_ph;
				if (ph == tls_sni_pkg::TP_SKIP) begin
					if (off < su_n) begin
						tp_n = tls_sni_pkg::TP_SKIP;
						done = 1'b1;
					end else begin
						ph = sn_n;
					end
				end
				if (!done) begin
					case (ph)
						tls_sni_pkg::TP_SID, tls_sni_pkg::TP_COMP: begin
							if (off + EW'(1) > body_end_n) begin
								pend_n = tls_sni_pkg::V_MALFORMED;
								tp_n = tls_sni_pkg::TP_DONE; done = 1'b1;
							end
						end
						tls_sni_pkg::TP_CSLEN: begin
							if (off + EW'(2) > body_end_n) begin
								pend_n = tls_sni_pkg::V_MALFORMED;
								tp_n = tls_sni_pkg::TP_DONE; done = 1'b1;
							end
						end
						tls_sni_pkg::TP_EXTLEN: begin
							if (off == body_end_n) begin
								pend_n = tls_sni_pkg::V_NONE;
								tp_n = tls_sni_pkg::TP_DONE; done = 1'b1;
							end else if (off + EW'(2) > body_end_n) begin
								pend_n = tls_sni_pkg::V_MALFORMED;
								tp_n = tls_sni_pkg::TP_DONE; done = 1'b1;
							end
						end
						tls_sni_pkg::TP_EXTHDR: begin
							if (off + EW'(4) > ext_end_n) begin
								pend_n = tls_sni_pkg::V_NONE;
								tp_n = tls_sni_pkg::TP_DONE; done = 1'b1;
							end
						end
						tls_sni_pkg::TP_LISTLEN: begin
							if (off + EW'(2) > cee_n) begin
								pend_n = tls_sni_pkg::V_MALFORMED;
								tp_n = tls_sni_pkg::TP_DONE; done = 1'b1;
							end
						end
						tls_sni_pkg::TP_ENTRY: begin
							// list exhausted: skip rest of extension
							if (off + EW'(3) > le_n) begin
								su_n = cee_n;
								sn_n = tls_sni_pkg::TP_EXTHDR;
								if (off < cee_n) begin
									tp_n = tls_sni_pkg::TP_SKIP; done = 1'b1;
								end else if (off + EW'(4) > ext_end_n) begin
									pend_n = tls_sni_pkg::V_NONE;
									tp_n = tls_sni_pkg::TP_DONE; done = 1'b1;
								end else begin
									ph = tls_sni_pkg::TP_EXTHDR;
								end
							end
						end
						default: ;
					endcase
				end
				if (!done) begin
					tp_n = ph;
					acc_n = '0;
					cnt_n = '0;
				end
			end
		end

		// verdict on the final byte
		tcnt_e = EW'(tcnt_n);
		case (fp_n)
			tls_sni_pkg::FP_IPOPT, tls_sni_pkg::FP_TCPOPT: vd = tls_sni_pkg::V_MALFORMED;
			tls_sni_pkg::FP_TCP:  vd = tls_sni_pkg::V_INCOMPLETE;
			tls_sni_pkg::FP_DONE: vd = fv_n;
			tls_sni_pkg::FP_PAYLOAD: begin
				if (!raw_n) begin
					poff = pstart_n;
					plen = (tcnt_e > EW'(tls_sni_pkg::PLEN_MAX)) ?
						tls_sni_pkg::PLEN_MAX : tcnt_e[16:0];
				end
				if (!raw_n && tcnt_n == '0) begin
					vd = tls_sni_pkg::V_NOT_TLS;
				end else if (nbs_q == 17'd0) begin
					vd = tls_sni_pkg::V_MALFORMED;
				end else if (tcnt_e < EW'(5)) begin
					vd = tls_sni_pkg::V_INCOMPLETE; need = 17'd5;
				end else if (rec_end_n == 17'd0) begin
					vd = tls_sni_pkg::V_NOT_TLS;
				end else if (EW'(rec_end_n) > tcnt_e) begin
					vd = tls_sni_pkg::V_INCOMPLETE; need = rec_end_n;
				end else begin
					vd = pend_n;
				end
			end
			default: vd = tls_sni_pkg::V_NOT_TLS;
		endcase
	end

	// result items
	always_comb begin
		tls_sni_pkg::out_t nm, vt;
		nm = '0;
		nm.item_kind = tls_sni_pkg::KIND_NAME;
		nm.name_byte = b;
		vt = '0;
		vt.item_kind = tls_sni_pkg::KIND_VERDICT;
		vt.verdict = vd;
		vt.bytes_needed = need;
		vt.payload_offset = poff;
		vt.payload_length = plen;
		item0 = emit ? nm : vt;
		item1 = vt;
		push_cnt = in_we ? (2'(emit) + 2'(eoi)) : 2'd0;
	end

	// state registers; a final byte returns to the start state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; fp_q <= tls_sni_pkg::FP_START; tp_q <= tls_sni_pkg::TP_REC;
			sn_q <= tls_sni_pkg::TP_REC; pend_q <= tls_sni_pkg::V_NONE;
			fv_q <= tls_sni_pkg::V_NOT_TLS; acc_q <= '0; cnt_q <= '0;
			dot_q <= 1'b0; sni_q <= 1'b0; raw_q <= 1'b0; lim_q <= 1'b0;
			rec_end_q <= '0; body_end_q <= '0; ext_end_q <= '0; cee_q <= '0;
			le_q <= '0; su_q <= '0; nrem_q <= '0; ntot_q <= '0; vlan_q <= '0;
			ip_end_q <= '0; tlim_q <= '0; pstart_q <= '0; hdr_q <= '0;
			verihl_q <= '0; proto_q <= '0; tcnt_q <= '0; etype_q <= '0;
			iptot_q <= '0; frag_q <= '0; ihl_q <= '0; tcph_q <= '0;
		end else if (in_we && eoi) begin
			pos_q <= '0; fp_q <= tls_sni_pkg::FP_START; tp_q <= tls_sni_pkg::TP_REC;
			sn_q <= tls_sni_pkg::TP_REC; pend_q <= tls_sni_pkg::V_NONE;
			fv_q <= tls_sni_pkg::V_NOT_TLS; acc_q <= '0; cnt_q <= '0;
			dot_q <= 1'b0; sni_q <= 1'b0; raw_q <= 1'b0; lim_q <= 1'b0;
			rec_end_q <= '0; body_end_q <= '0; ext_end_q <= '0; cee_q <= '0;
			le_q <= '0; su_q <= '0; nrem_q <= '0; ntot_q <= '0; vlan_q <= '0;
			ip_end_q <= '0; tlim_q <= '0; pstart_q <= '0; hdr_q <= '0;
			verihl_q <= '0; proto_q <= '0; tcnt_q <= '0; etype_q <= '0;
			iptot_q <= '0; frag_q <= '0; ihl_q <= '0; tcph_q <= '0;
		end else if (in_we) begin
			pos_q <= pos_n; fp_q <= fp_n; tp_q <= tp_n; sn_q <= sn_n;
			pend_q <= pend_n; fv_q <= fv_n; acc_q <= acc_n; cnt_q <= cnt_n;
			dot_q <= dot_n; sni_q <= sni_n; raw_q <= raw_n; lim_q <= lim_n;
			rec_end_q <= rec_end_n; body_end_q <= body_end_n; ext_end_q <= ext_end_n;
			cee_q <= cee_n; le_q <= le_n; su_q <= su_n; nrem_q <= nrem_n;
			ntot_q <= ntot_n; vlan_q <= vlan_n; ip_end_q <= ip_end_n;
			tlim_q <= tlim_n; pstart_q <= pstart_n; hdr_q <= hdr_n;
			verihl_q <= verihl_n; proto_q <= proto_n; tcnt_q <= tcnt_n;
			etype_q <= etype_n; iptot_q <= iptot_n; frag_q <= frag_n;
			ihl_q <= ihl_n; tcph_q <= tcph_n;
		end
	end

`ifndef SYNTHESIS
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_we && eoi |=> fp_q == tls_sni_pkg::FP_START && pos_q == '0)
		else $error("parser did not restart after final byte");
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push_cnt == 2'd2 |-> item0.item_kind == tls_sni_pkg::KIND_NAME &&
		item1.item_kind == tls_sni_pkg::KIND_VERDICT)
		else $error("two-item push not name then verdict");
	a_verdict_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_we && !eoi |-> push_cnt != 2'd2 && (push_cnt == 2'd0 ||
		item0.item_kind == tls_sni_pkg::KIND_NAME))
		else $error("verdict produced before final byte");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tcnt_q <= pos_q)
		else $error("payload count ahead of byte position");
`endif

endmodule

/* hdl/tls_sni_frame_extractor_unit.sv */
// TLS ClientHello server-name extractor.
// Input channel: one byte per transaction (in_data.data_byte), with
// in_data.end_of_input set on the last byte of a frame or bare payload.
// Output channel: for each input byte zero or one provisional hostname byte
// (item_kind 0); after the last byte one verdict item (item_kind 1) carrying
// verdict, bytes_needed, payload_offset and payload_length.
// Config channel: cfg_index 0 writes input_mode, 1 writes name_buffer_size;
// write only while no frame is in flight.
// Results of a byte are registered in the output queue when it is accepted.
// Throughput: one byte per cycle while in_ready is high; each byte is handled
// by a single pass of compare and counter logic between the parse state
// registers, and results land in a four-entry output queue.
// Reset: parse state returns to the start of a frame, input_mode to 0,
// name_buffer_size to 256, the output queue empties.
// Output stall: in_ready drops while the queue has fewer than two free
// entries, so no result is ever dropped; bytes resume as soon as the
// receiver drains the queue.
module tls_sni_frame_extractor_unit #(
	parameter int unsigned MAX_NAME        = 256,
	parameter int unsigned MAX_INPUT_BYTES = 131072
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tls_sni_pkg::in_t   in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output tls_sni_pkg::out_t  out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [16:0]        cfg_data
);

	logic [1:0]        push_cnt;
	tls_sni_pkg::out_t item0, item1;
	logic              space;

	assign in_ready  = space;
	assign cfg_ready = 1'b1;

	// byte parser
	tls_sni_parser #(
		.MAX_NAME        (MAX_NAME),
		.MAX_INPUT_BYTES (MAX_INPUT_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_we     (in_valid && in_ready),
		.in_data   (in_data),
		.push_cnt  (push_cnt),
		.item0     (item0),
		.item1     (item1)
	);

	// result queue
	tls_sni_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (push_cnt),
		.item0     (item0),
		.item1     (item1),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

/* tb/tb_tls_sni_frame_extractor_unit.sv */
module tb_tls_sni_frame_extractor_unit;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NAME_CAP = 256;
	localparam int unsigned INPUT_CAP = 131072;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int NO_TYPED = -1;
	localparam int END_LATENCY = 20;

	// directed scenario kinds
	typedef enum int {
		K_ONLY_TYPE, K_TINY, K_RAW_OK, K_ROOT_DOT, K_BAD_CHAR, K_NO_SNI, K_SHORT_LABEL,
		K_NAME_LONG, K_ZERO_BUF, K_TRUNC, K_NOT_HS, K_NOT_HELLO, K_SKIP_ENTRY,
		K_ETH_OK, K_TWO_TAGS, K_THREE_TAGS, K_OTHER_ETYPE, K_FRAGMENT, K_SHORT_TCP,
		K_BAD_IHL, K_IP_OPT_END, K_BAD_DOFF, K_CLAMP, K_MAX_NAME, K_NOT_IPV4
	} scenario_t;

	typedef struct {
		bit raw;
		int unsigned nbuf;
		scenario_t kind;
		int typed;
	} row_t;

	typedef struct {
		bit raw;
		int vlans;
		bit bad_etype;
		int ip_ver;
		int ihl_words;
		int frag;
		int tcp_words;
		int cut;
		int trailer;
		int ip_short;
		bit tls;
		bit rec_bad;
		bit hs_bad;
		int sid_len;
		int cs_pairs;
		int pre_ext;
		bit sni;
		bit other_entry;
		int host_len;
		int style;
		int flip;
	} knobs_t;

	typedef struct {
		logic        index;
		logic [16:0] data;
	} reg_write_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	tls_sni_pkg::in_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	tls_sni_pkg::out_t out_data;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic      cfg_index = 1'b0;
	logic [16:0] cfg_data = '0;

	tls_sni_pkg::in_t  byte_q[$];
	int         typed_q[$];
	reg_write_t reg_q[$];
	tls_sni_pkg::out_t sni_items_due[$];

	int  idle_phase = 0;
	logic hold = 1'b0;
	int  cycles = 0;
	int  fails = 0;
	int  checked = 0;
	int  frames = 0;
	int  sent_bytes = 0;
	int  found_count = 0;
	bit  shadow_mode;
	int unsigned shadow_nbuf;

	tls_sni_frame_extractor_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// ---------------- predictor state ----------------
	bit          p_mode;
	int unsigned p_nbuf;
	tls_sni_pkg::fp_t      w_ph;
	tls_sni_pkg::tp_t      t_ph, t_next;
	tls_sni_pkg::verdict_t t_pend, w_verd;
	bit          sni_ext, bare, clamp, dot;
	int unsigned acc, acnt, rec_end, body_lim, ext_lim, cur_ext_lim, list_lim, skip_to;
	int unsigned name_left, host_total, vlans, ip_lim, pay_start, tls_cap, tls_pos;
	int unsigned etype, hdr0, vihl, ihl_b, ip_len, proto, frag, tcp_len, pos;

	function automatic void clear_parse();
		pos = 0; acc = 0; acnt = 0;
		w_ph = tls_sni_pkg::FP_START; t_ph = tls_sni_pkg::TP_REC;
		t_next = tls_sni_pkg::TP_REC;
		t_pend = tls_sni_pkg::V_NONE; w_verd = tls_sni_pkg::V_NOT_TLS;
		dot = 0; sni_ext = 0; bare = 0; clamp = 0;
		rec_end = 0; body_lim = 0; ext_lim = 0; cur_ext_lim = 0;
		list_lim = 0; skip_to = 0; name_left = 0; host_total = 0;
		vlans = 0; ip_lim = 0; pay_start = 0; tls_cap = 0; tls_pos = 0;
		etype = 0; hdr0 = 0; vihl = 0; ihl_b = 0; ip_len = 0; proto = 0; frag = 0;
		tcp_len = 0;
	endfunction

	function automatic void settle(tls_sni_pkg::verdict_t v);
		t_pend = v;
		t_ph = tls_sni_pkg::TP_DONE;
	endfunction

	// enter a tls phase at offset off, applying its entry bounds
	function automatic void enter_tls(tls_sni_pkg::tp_t ph, int unsigned off);
		while (1) begin
			case (ph)
				tls_sni_pkg::TP_SKIP: begin
					if (off < skip_to) begin
						t_ph = tls_sni_pkg::TP_SKIP;
						return;
					end
					ph = t_next;
					continue;
				end
				tls_sni_pkg::TP_SID, tls_sni_pkg::TP_COMP: if (off + 1 > body_lim) begin
					settle(tls_sni_pkg::V_MALFORMED);
					return;
				end
				tls_sni_pkg::TP_CSLEN: if (off + 2 > body_lim) begin
					settle(tls_sni_pkg::V_MALFORMED);
					return;
				end
				tls_sni_pkg::TP_EXTLEN: begin
					if (off == body_lim) begin
						settle(tls_sni_pkg::V_NONE);
						return;
					end
					if (off + 2 > body_lim) begin
						settle(tls_sni_pkg::V_MALFORMED);
						return;
					end
				end
				tls_sni_pkg::TP_EXTHDR: if (off + 4 > ext_lim) begin
					settle(tls_sni_pkg::V_NONE);
					return;
				end
				tls_sni_pkg::TP_LISTLEN: if (off + 2 > cur_ext_lim) begin
					settle(tls_sni_pkg::V_MALFORMED);
					return;
				end
				tls_sni_pkg::TP_ENTRY: if (off + 3 > list_lim) begin
					skip_to = cur_ext_lim;
					t_next = tls_sni_pkg::TP_EXTHDR;
					ph = tls_sni_pkg::TP_SKIP;
					continue;
				end
				default: ;
			endcase
			t_ph = ph;
			acc = 0;
			acnt = 0;
			return;
		end
	endfunction

	function automatic void skip_then(int unsigned target, tls_sni_pkg::tp_t nxt,
			int unsigned off);
		skip_to = target;
		t_next = nxt;
		enter_tls(tls_sni_pkg::TP_SKIP, off);
	endfunction

	function automatic bit is_host_char(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
			(c >= "0" && c <= "9") || c == "." || c == "-" || c == "_";
	endfunction

	// one tls payload byte at payload offset t
	function automatic void tls_eat(logic [7:0] b, int unsigned t, ref int emit);
		int unsigned off, v, hs, ntype;
		off = t + 1;
		if (t_ph == tls_sni_pkg::TP_DONE)
			return;
		acc = ((acc << 8) | b) & 24'hffffff;
		acnt++;
		v = acc & 16'hffff;
		case (t_ph)
			tls_sni_pkg::TP_REC: begin
				if (t == 0 && b != tls_sni_pkg::REC_HANDSHAKE) begin
					settle(tls_sni_pkg::V_NOT_TLS);
					return;
				end
				if (acnt == 5) begin
					rec_end = 5 + v;
					if (v < 4) settle(tls_sni_pkg::V_MALFORMED);
					else enter_tls(tls_sni_pkg::TP_HSTYPE, off);
				end
			end
			tls_sni_pkg::TP_HSTYPE: if (b != tls_sni_pkg::HS_CLIENT_HELLO)
					settle(tls_sni_pkg::V_NOT_TLS);
				else enter_tls(tls_sni_pkg::TP_HSLEN, off);
			tls_sni_pkg::TP_HSLEN: if (acnt == 3) begin
				hs = acc;
				if (hs < tls_sni_pkg::HELLO_FIXED_LEN || hs > rec_end - 9) begin
					settle(tls_sni_pkg::V_MALFORMED);
					return;
				end
				body_lim = 9 + hs;
				skip_then(9 + tls_sni_pkg::HELLO_FIXED_LEN, tls_sni_pkg::TP_SID, off);
			end
			tls_sni_pkg::TP_SKIP: enter_tls(tls_sni_pkg::TP_SKIP, off);
			tls_sni_pkg::TP_SID: if (off + b > body_lim) settle(tls_sni_pkg::V_MALFORMED);
				else skip_then(off + b, tls_sni_pkg::TP_CSLEN, off);
			tls_sni_pkg::TP_CSLEN: if (acnt == 2) begin
				if (off + v > body_lim || v < 2 || v[0]) settle(tls_sni_pkg::V_MALFORMED);
				else skip_then(off + v, tls_sni_pkg::TP_COMP, off);
			end
			tls_sni_pkg::TP_COMP: if (b < 1 || off + b > body_lim)
					settle(tls_sni_pkg::V_MALFORMED);
				else skip_then(off + b, tls_sni_pkg::TP_EXTLEN, off);
			tls_sni_pkg::TP_EXTLEN: if (acnt == 2) begin
				if (off + v > body_lim) begin
					settle(tls_sni_pkg::V_MALFORMED);
					return;
				end
				ext_lim = off + v;
				enter_tls(tls_sni_pkg::TP_EXTHDR, off);
			end
			tls_sni_pkg::TP_EXTHDR: begin
				if (acnt == 2)
					sni_ext = (v == 0);
				if (acnt == 4) begin
					if (off + v > ext_lim) begin
						settle(tls_sni_pkg::V_MALFORMED);
						return;
					end
					if (!sni_ext) begin
						skip_then(off + v, tls_sni_pkg::TP_EXTHDR, off);
					end else begin
						cur_ext_lim = off + v;
						enter_tls(tls_sni_pkg::TP_LISTLEN, off);
					end
				end
			end
			tls_sni_pkg::TP_LISTLEN: if (acnt == 2) begin
				if (off + v > cur_ext_lim) begin
					settle(tls_sni_pkg::V_MALFORMED);
					return;
				end
				list_lim = off + v;
				enter_tls(tls_sni_pkg::TP_ENTRY, off);
			end
			tls_sni_pkg::TP_ENTRY: if (acnt == 3) begin
				ntype = (acc >> 16) & 8'hff;
				if (off + v > list_lim) begin
					settle(tls_sni_pkg::V_MALFORMED);
					return;
				end
				if (ntype != 0) begin
					skip_then(off + v, tls_sni_pkg::TP_ENTRY, off);
					return;
				end
				if (v == 0 || v >= p_nbuf || v >= NAME_CAP) begin
					settle(tls_sni_pkg::V_MALFORMED);
					return;
				end
				host_total = v;
				name_left = v;
				dot = 0;
				t_ph = tls_sni_pkg::TP_NAME;
			end
			tls_sni_pkg::TP_NAME: begin
				if (!is_host_char(b)) begin
					settle(tls_sni_pkg::V_MALFORMED);
					return;
				end
				if (b == ".") dot = 1;
				name_left--;
				if (!(name_left == 0 && b == "." && host_total > 1))
					emit = b;
				if (name_left == 0) begin
					if (!dot && host_total < 4) settle(tls_sni_pkg::V_MALFORMED);
					else settle(tls_sni_pkg::V_FOUND);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void frame_stop(tls_sni_pkg::verdict_t v);
		w_verd = v;
		w_ph = tls_sni_pkg::FP_DONE;
	endfunction

	function automatic void type_known(int unsigned off);
		hdr0 = off;
		if ((etype == tls_sni_pkg::ETYPE_VLAN || etype == tls_sni_pkg::ETYPE_QINQ) &&
				vlans < 2)
			w_ph = tls_sni_pkg::FP_VLAN;
		else if (etype == tls_sni_pkg::ETYPE_IPV4) w_ph = tls_sni_pkg::FP_IP;
		else frame_stop(tls_sni_pkg::V_NOT_TLS);
	endfunction

	function automatic void ip_done(int unsigned off);
		if (ip_len < ihl_b) begin
			frame_stop(tls_sni_pkg::V_MALFORMED);
			return;
		end
		if (proto != tls_sni_pkg::IP_PROTO_TCP ||
				(frag & tls_sni_pkg::FRAG_OFFSET_MASK) != 0) begin
			frame_stop(tls_sni_pkg::V_NOT_TLS);
			return;
		end
		ip_lim = hdr0 + ip_len;
		hdr0 = off;
		w_ph = tls_sni_pkg::FP_TCP;
	endfunction

	function automatic void tcp_done(int unsigned off);
		pay_start = off;
		clamp = ip_lim > off;
		tls_cap = clamp ? ip_lim - off : 0;
		w_ph = tls_sni_pkg::FP_PAYLOAD;
	endfunction

	// one frame byte at frame position p
	function automatic void frame_eat(logic [7:0] b, int unsigned p, ref int emit);
		int unsigned i;
		if (w_ph == tls_sni_pkg::FP_START) begin
			bare = p_mode;
			if (bare) begin
				pay_start = 0;
				clamp = 0;
				w_ph = tls_sni_pkg::FP_PAYLOAD;
			end else begin
				w_ph = tls_sni_pkg::FP_ETH;
			end
		end
		i = p - hdr0;
		case (w_ph)
			tls_sni_pkg::FP_ETH: begin
				if (p >= 12) etype = ((etype << 8) | b) & 16'hffff;
				if (p == 13) type_known(p + 1);
			end
			tls_sni_pkg::FP_VLAN: begin
				if (i >= 2) etype = ((etype << 8) | b) & 16'hffff;
				if (i == 3) begin
					vlans++;
					type_known(p + 1);
				end
			end
			tls_sni_pkg::FP_IP: begin
				if (i == 0) vihl = b;
				if (i == 2 || i == 3) ip_len = ((ip_len << 8) | b) & 16'hffff;
				if (i == 6 || i == 7) frag = ((frag << 8) | b) & 16'hffff;
				if (i == 9) proto = b;
				if (i == 19) begin
					if ((vihl >> 4) != 4) begin
						frame_stop(tls_sni_pkg::V_NOT_TLS);
						return;
					end
					ihl_b = (vihl & 8'h0f) * 4;
					if (ihl_b < 20) frame_stop(tls_sni_pkg::V_MALFORMED);
					else if (ihl_b == 20) ip_done(p + 1);
					else w_ph = tls_sni_pkg::FP_IPOPT;
				end
			end
			tls_sni_pkg::FP_IPOPT: if (i + 1 == ihl_b) ip_done(p + 1);
			tls_sni_pkg::FP_TCP: begin
				if (i == 12) tcp_len = (b >> 4) * 4;
				if (i == 19) begin
					if (tcp_len < 20) frame_stop(tls_sni_pkg::V_MALFORMED);
					else if (tcp_len == 20) tcp_done(p + 1);
					else w_ph = tls_sni_pkg::FP_TCPOPT;
				end
			end
			tls_sni_pkg::FP_TCPOPT: if (i + 1 == tcp_len) tcp_done(p + 1);
			tls_sni_pkg::FP_PAYLOAD: if (!clamp || tls_pos < tls_cap) begin
				tls_eat(b, tls_pos, emit);
				tls_pos++;
			end
			default: ;
		endcase
	endfunction

	// expected result items of one accepted byte
	function automatic void sni_predict_byte(tls_sni_pkg::in_t x, int typed);
		int emit;
		tls_sni_pkg::out_t r;
		tls_sni_pkg::verdict_t v;
		int unsigned need, poff, plen;
		emit = -1;
		v = tls_sni_pkg::V_NOT_TLS;
		need = 0;
		poff = 0;
		plen = 0;
		if (pos < INPUT_CAP) begin
			frame_eat(x.data_byte, pos, emit);
			pos++;
		end
		if (emit >= 0) begin
			r = '0;
			r.item_kind = tls_sni_pkg::KIND_NAME;
			r.name_byte = emit[7:0];
			sni_items_due.push_back(r);
		end
		if (!x.end_of_input)
			return;
		case (w_ph)
			tls_sni_pkg::FP_IPOPT, tls_sni_pkg::FP_TCPOPT: v = tls_sni_pkg::V_MALFORMED;
			tls_sni_pkg::FP_TCP: v = tls_sni_pkg::V_INCOMPLETE;
			tls_sni_pkg::FP_DONE: v = w_verd;
			tls_sni_pkg::FP_PAYLOAD: begin
				if (!bare) begin
					poff = pay_start;
					plen = tls_pos > tls_sni_pkg::PLEN_MAX ? tls_sni_pkg::PLEN_MAX : tls_pos;
				end
				if (!bare && tls_pos == 0) v = tls_sni_pkg::V_NOT_TLS;
				else if (p_nbuf == 0) v = tls_sni_pkg::V_MALFORMED;
				else if (tls_pos < 5) begin
					v = tls_sni_pkg::V_INCOMPLETE;
					need = 5;
				end else if (rec_end == 0) v = tls_sni_pkg::V_NOT_TLS;
				else if (rec_end > tls_pos) begin
					v = tls_sni_pkg::V_INCOMPLETE;
					need = rec_end;
				end else v = t_pend;
			end
			default: v = tls_sni_pkg::V_NOT_TLS;
		endcase
		if (typed != NO_TYPED)
			v = tls_sni_pkg::verdict_t'(typed);
		r = '0;
		r.item_kind = tls_sni_pkg::KIND_VERDICT;
		r.verdict = v;
		r.bytes_needed = need[16:0];
		r.payload_offset = poff[7:0];
		r.payload_length = plen[16:0];
		sni_items_due.push_back(r);
		clear_parse();
	endfunction

	// ---------------- channel drivers ----------------
	function automatic bit roll_idle(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	// byte sender
	always @(posedge clk) begin
		logic nv;
		tls_sni_pkg::in_t nd;
		nv = in_valid;
		nd = in_data;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sni_predict_byte(in_data, typed_q.pop_front());
				void'(byte_q.pop_front());
				nv = 1'b0;
			end
			if (!nv && byte_q.size() > 0 &&
					!roll_idle(idle_phase == 0 ? 8 : idle_phase == 1 ? 70 : 0)) begin
				nv = 1'b1;
				nd = byte_q[0];
			end
		end
		in_valid <= nv;
		in_data <= nd;
	end

	// register writer
	always @(posedge clk) begin
		logic nv;
		nv = cfg_valid;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == tls_sni_pkg::REG_INPUT_MODE) p_mode = cfg_data[0];
				else p_nbuf = cfg_data;
				void'(reg_q.pop_front());
				nv = 1'b0;
			end
			if (!nv && reg_q.size() > 0) begin
				nv = 1'b1;
				cfg_index <= reg_q[0].index;
				cfg_data <= reg_q[0].data;
			end
		end
		cfg_valid <= nv;
	end

	function automatic void check_field(string name, int unsigned exp, int unsigned act);
		if (exp != act) begin
			$error("%s expected %0d got %0d", name, exp, act);
			fails++;
		end
	endfunction

	// result receiver and checker
	always @(posedge clk) begin
		tls_sni_pkg::out_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (sni_items_due.size() == 0) begin
					$error("result item with nothing expected");
					fails++;
				end else begin
					e = sni_items_due.pop_front();
					checked++;
					if (e.item_kind == tls_sni_pkg::KIND_VERDICT &&
							e.verdict == tls_sni_pkg::V_FOUND)
						found_count++;
					check_field("item_kind", e.item_kind, out_data.item_kind);
					check_field("name_byte", e.name_byte, out_data.name_byte);
					check_field("verdict", e.verdict, out_data.verdict);
					check_field("bytes_needed", e.bytes_needed, out_data.bytes_needed);
					check_field("payload_offset", e.payload_offset, out_data.payload_offset);
					check_field("payload_length", e.payload_length, out_data.payload_length);
				end
			end
			out_ready <= !hold &&
				!roll_idle(idle_phase == 0 ? 70 : idle_phase == 1 ? 8 : 0);
		end
	end

	// long receiver hold-off once idling stops
	initial begin
		wait (idle_phase == 2);
		@(posedge clk);
		hold <= 1'b1;
		repeat (400) @(posedge clk);
		hold <= 1'b0;
	end

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ---------------- stimulus builders ----------------
	function automatic void put16(ref logic [7:0] q[$], input int unsigned v);
		q.push_back(v[15:8]);
		q.push_back(v[7:0]);
	endfunction

	function automatic logic [7:0] host_char(bit allow_dot);
		int unsigned k;
		k = $urandom_range(0, allow_dot ? 64 : 61);
		if (k < 26) return "a" + k;
		if (k < 52) return "A" + k - 26;
		if (k < 62) return "0" + k - 52;
		if (k == 62) return ".";
		if (k == 63) return "-";
		return "_";
	endfunction

	// name styles: 0 plain, 1 trailing root dot, 2 bad character, 3 single label with no dot
	function automatic void make_name(int style, int len, ref logic [7:0] q[$]);
		logic [7:0] c;
		for (int n = 0; n < len; n++)
			q.push_back(host_char(style != 3));
		if (style == 1) q[len - 1] = ".";
		if (style == 2) begin
			do c = $urandom_range(0, 255); while (is_host_char(c));
			q[$urandom_range(0, len - 1)] = c;
		end
	endfunction

	function automatic void build_hello(knobs_t k, ref logic [7:0] q[$]);
		logic [7:0] body[$], ext[$], sni_d[$], ent[$], hs[$], nm[$];
		int len;
		body.push_back(8'h03);
		body.push_back(8'h03);
		repeat (32) body.push_back($urandom_range(0, 255));
		body.push_back(k.sid_len);
		repeat (k.sid_len) body.push_back($urandom_range(0, 255));
		put16(body, 2 * k.cs_pairs);
		repeat (2 * k.cs_pairs) body.push_back($urandom_range(0, 255));
		body.push_back(8'h01);
		body.push_back(8'h00);
		repeat (k.pre_ext) begin
			put16(ext, $urandom_range(1, 65535));
			len = $urandom_range(0, 4);
			put16(ext, len);
			repeat (len) ext.push_back($urandom_range(0, 255));
		end
		if (k.sni) begin
			if (k.other_entry) begin
				ent.push_back(8'h01);
				put16(ent, 2);
				repeat (2) ent.push_back($urandom_range(0, 255));
			end
			make_name(k.style, k.host_len, nm);
			ent.push_back(8'h00);
			put16(ent, k.host_len);
			ent = {ent, nm};
			put16(sni_d, ent.size());
			sni_d = {sni_d, ent};
			put16(ext, 0);
			put16(ext, sni_d.size());
			ext = {ext, sni_d};
		end
		put16(body, ext.size());
		body = {body, ext};
		hs.push_back(k.hs_bad ? 8'h02 : tls_sni_pkg::HS_CLIENT_HELLO);
		hs.push_back(8'h00);
		put16(hs, body.size());
		hs = {hs, body};
		q.push_back(k.rec_bad ? 8'h17 : tls_sni_pkg::REC_HANDSHAKE);
		q.push_back(8'h03);
		q.push_back(8'h01);
		put16(q, hs.size());
		q = {q, hs};
	endfunction

	function automatic void build_frame(knobs_t k, ref logic [7:0] f[$]);
		logic [7:0] pl[$];
		int ihl, tcp, total;
		if (k.tls) build_hello(k, pl);
		else repeat ($urandom_range(1, 40)) pl.push_back($urandom_range(0, 255));
		if (k.flip >= 0 && k.flip < pl.size())
			pl[k.flip] = pl[k.flip] ^ $urandom_range(1, 255);
		if (k.raw) begin
			f = pl;
		end else begin
			ihl = k.ihl_words * 4;
			tcp = k.tcp_words * 4;
			repeat (12) f.push_back($urandom_range(0, 255));
			for (int t = 0; t <= k.vlans; t++) begin
				if (t > 0) repeat (2) f.push_back($urandom_range(0, 255));
				if (t < k.vlans)
					put16(f, $urandom_range(0, 1) ? tls_sni_pkg::ETYPE_VLAN :
						tls_sni_pkg::ETYPE_QINQ);
				else put16(f, k.bad_etype ? 16'h86dd : tls_sni_pkg::ETYPE_IPV4);
			end
			total = (ihl < 20 ? 20 : ihl) + tcp + pl.size();
			if (k.ip_short == 1) total = ihl + $urandom_range(0, 10);
			if (k.ip_short == 2) total = $urandom_range(0, ihl - 1);
			f.push_back({k.ip_ver[3:0], k.ihl_words[3:0]});
			f.push_back($urandom_range(0, 255));
			put16(f, total);
			put16(f, $urandom_range(0, 65535));
			put16(f, {3'($urandom_range(0, 3)), k.frag[12:0]});
			f.push_back($urandom_range(0, 255));
			f.push_back(tls_sni_pkg::IP_PROTO_TCP);
			repeat (10) f.push_back($urandom_range(0, 255));
			repeat (ihl - 20) f.push_back($urandom_range(0, 255));
			repeat (12) f.push_back($urandom_range(0, 255));
			f.push_back({k.tcp_words[3:0], 4'($urandom_range(0, 15))});
			repeat (7) f.push_back($urandom_range(0, 255));
			repeat (tcp - 20) f.push_back($urandom_range(0, 255));
			f = {f, pl};
			repeat (k.trailer) f.push_back($urandom_range(0, 255));
		end
		if (k.cut > 0 && k.cut < f.size())
			f = f[0:k.cut - 1];
	endfunction

	function automatic knobs_t plain_knobs(bit raw);
		knobs_t k;
		k.raw = raw;
		k.vlans = 0;
		k.bad_etype = 0;
		k.ip_ver = 4;
		k.ihl_words = 5;
		k.frag = 0;
		k.tcp_words = 5;
		k.cut = 0;
		k.trailer = 0;
		k.ip_short = 0;
		k.tls = 1;
		k.rec_bad = 0;
		k.hs_bad = 0;
		k.sid_len = $urandom_range(0, 32);
		k.cs_pairs = $urandom_range(1, 3);
		k.pre_ext = $urandom_range(0, 2);
		k.sni = 1;
		k.other_entry = 0;
		k.host_len = $urandom_range(4, 16);
		k.style = 0;
		k.flip = -1;
		return k;
	endfunction

	task automatic wait_idle();
		while (byte_q.size() != 0 || in_valid || sni_items_due.size() != 0 ||
				reg_q.size() != 0 || cfg_valid)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_regs(bit mode, int unsigned nbuf, bit force_all);
		reg_write_t w;
		if (!force_all && mode == shadow_mode && nbuf == shadow_nbuf)
			return;
		wait_idle();
		if (force_all || mode != shadow_mode) begin
			w.index = tls_sni_pkg::REG_INPUT_MODE;
			w.data = mode;
			reg_q.push_back(w);
		end
		if (force_all || nbuf != shadow_nbuf) begin
			w.index = tls_sni_pkg::REG_NAME_BUF;
			w.data = nbuf[16:0];
			reg_q.push_back(w);
		end
		shadow_mode = mode;
		shadow_nbuf = nbuf;
		while (reg_q.size() != 0 || cfg_valid)
			@(posedge clk);
	endtask

	task automatic send_frame(knobs_t k, int typed);
		logic [7:0] f[$];
		tls_sni_pkg::in_t x;
		build_frame(k, f);
		foreach (f[n]) begin
			x.data_byte = f[n];
			x.end_of_input = (n == f.size() - 1);
			byte_q.push_back(x);
			typed_q.push_back(x.end_of_input ? typed : NO_TYPED);
		end
		sent_bytes += f.size();
		frames++;
	endtask

	function automatic knobs_t scenario_knobs(row_t r);
		knobs_t k;
		k = plain_knobs(r.raw);
		case (r.kind)
			K_ONLY_TYPE: k.cut = 1;
			K_TINY: begin
				k.tls = 0;
				k.cut = 2;
			end
			K_ROOT_DOT: k.style = 1;
			K_BAD_CHAR: k.style = 2;
			K_NO_SNI: k.sni = 0;
			K_SHORT_LABEL: begin
				k.style = 3;
				k.host_len = 3;
			end
			K_NAME_LONG: k.host_len = 5;
			K_TRUNC: k.cut = 30;
			K_NOT_HS: k.rec_bad = 1;
			K_NOT_HELLO: k.hs_bad = 1;
			K_SKIP_ENTRY: k.other_entry = 1;
			K_TWO_TAGS: k.vlans = 2;
			K_THREE_TAGS: k.vlans = 3;
			K_OTHER_ETYPE: k.bad_etype = 1;
			K_FRAGMENT: k.frag = 13'h1fff;
			K_SHORT_TCP: k.cut = 14 + 20 + 10;
			K_BAD_IHL: k.ihl_words = 4;
			K_IP_OPT_END: begin
				k.ihl_words = 7;
				k.cut = 14 + 24;
			end
			K_BAD_DOFF: k.tcp_words = 3;
			K_CLAMP: begin
				k.trailer = 6;
				k.tcp_words = 15;
				k.ihl_words = 15;
			end
			K_MAX_NAME: k.host_len = NAME_CAP - 1;
			K_NOT_IPV4: k.ip_ver = 6;
			default: ;
		endcase
		return k;
	endfunction

	function automatic knobs_t random_knobs(bit raw);
		knobs_t k;
		int style_roll;
		k = plain_knobs(raw);
		k.vlans = $urandom_range(0, 19) == 0 ? 3 : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) k.ihl_words = $urandom_range(6, 15);
		if ($urandom_range(0, 3) == 0) k.tcp_words = $urandom_range(6, 15);
		k.trailer = $urandom_range(0, 1) ? $urandom_range(0, 8) : 0;
		k.host_len = $urandom_range(1, 24);
		style_roll = $urandom_range(0, 9);
		k.style = style_roll < 7 ? 0 : style_roll - 6;
		k.other_entry = $urandom_range(0, 4) == 0;
		// mostly well-formed; the rest break one thing
		if ($urandom_range(0, 4) == 0) begin
			case ($urandom_range(0, 11))
				0: k.cut = $urandom_range(1, 120);
				1: k.flip = $urandom_range(0, 90);
				2: k.rec_bad = 1;
				3: k.hs_bad = 1;
				4: k.sni = 0;
				5: k.tls = 0;
				6: k.ip_short = $urandom_range(1, 2);
				7: k.bad_etype = 1;
				8: k.frag = $urandom_range(1, 8191);
				9: k.ihl_words = $urandom_range(0, 4);
				10: k.tcp_words = $urandom_range(0, 4);
				default: k.ip_ver = $urandom_range(0, 15);
			endcase
		end
		return k;
	endfunction

	function automatic int unsigned pick_nbuf();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 2;
			2: return 10;
			3: return 65536;
			4, 5: return $urandom_range(1, 300);
			default: return 256;
		endcase
	endfunction

	// ---------------- main sequence ----------------
	initial begin
		row_t directed_rows[$];
		knobs_t k;
		int sent_mark;
		bit mode;
		int unsigned nbuf;

		p_mode = 0;
		p_nbuf = 256;
		clear_parse();
		shadow_mode = 0;
		shadow_nbuf = 256;

		directed_rows = '{
			'{1, 256,   K_ONLY_TYPE,   tls_sni_pkg::V_INCOMPLETE},
			'{1, 256,   K_TINY,        NO_TYPED},
			'{1, 256,   K_RAW_OK,      NO_TYPED},
			'{1, 256,   K_ROOT_DOT,    NO_TYPED},
			'{1, 256,   K_BAD_CHAR,    tls_sni_pkg::V_MALFORMED},
			'{1, 256,   K_NO_SNI,      NO_TYPED},
			'{1, 256,   K_SHORT_LABEL, tls_sni_pkg::V_MALFORMED},
			'{1, 5,     K_NAME_LONG,   tls_sni_pkg::V_MALFORMED},
			'{1, 0,     K_ZERO_BUF,    tls_sni_pkg::V_MALFORMED},
			'{1, 65536, K_TRUNC,       NO_TYPED},
			'{1, 65536, K_NOT_HS,      NO_TYPED},
			'{1, 65536, K_NOT_HELLO,   NO_TYPED},
			'{1, 65536, K_MAX_NAME,    NO_TYPED},
			'{0, 65536, K_SKIP_ENTRY,  NO_TYPED},
			'{0, 256,   K_ETH_OK,      NO_TYPED},
			'{0, 256,   K_TWO_TAGS,    NO_TYPED},
			'{0, 256,   K_THREE_TAGS,  tls_sni_pkg::V_NOT_TLS},
			'{0, 256,   K_OTHER_ETYPE, tls_sni_pkg::V_NOT_TLS},
			'{0, 256,   K_FRAGMENT,    tls_sni_pkg::V_NOT_TLS},
			'{0, 256,   K_SHORT_TCP,   tls_sni_pkg::V_INCOMPLETE},
			'{0, 256,   K_BAD_IHL,     tls_sni_pkg::V_MALFORMED},
			'{0, 256,   K_IP_OPT_END,  tls_sni_pkg::V_MALFORMED},
			'{0, 256,   K_BAD_DOFF,    NO_TYPED},
			'{0, 256,   K_CLAMP,       NO_TYPED},
			'{0, 256,   K_NOT_IPV4,    tls_sni_pkg::V_NOT_TLS}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part
		set_regs(1, 256, 1);
		foreach (directed_rows[n]) begin
			set_regs(directed_rows[n].raw, directed_rows[n].nbuf, 0);
			send_frame(scenario_knobs(directed_rows[n]), directed_rows[n].typed);
		end

		// random part in three idling phases
		for (int ph = 0; ph < 3; ph++) begin
			wait_idle();
			idle_phase = ph;
			sent_mark = sent_bytes;
			mode = shadow_mode;
			nbuf = shadow_nbuf;
			while (sent_bytes - sent_mark < 580) begin
				if ($urandom_range(0, 5) == 0) begin
					mode = $urandom_range(0, 1);
					nbuf = pick_nbuf();
				end
				set_regs(mode, nbuf, 0);
				k = random_knobs(mode);
				send_frame(k, NO_TYPED);
				while (byte_q.size() > 8) @(posedge clk);
			end
		end

		while (byte_q.size() != 0 || in_valid || sni_items_due.size() != 0)
			@(posedge clk);
		repeat (END_LATENCY) @(posedge clk);
		if (sni_items_due.size() != 0) begin
			$error("%0d expected result items never arrived", sni_items_due.size());
			fails++;
		end

		$display("run: %0d frames and payloads (%0d bytes) in both input modes, %0d results checked",
			frames, sent_bytes, checked);
		$display("run: %0d hostnames found, buffer sizes from 0 to 65536, long output stall",
			found_count);
		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
